// ----- rtl/fca_pkg.sv -----
// ---------------------------------------------------------------------------
// fca_pkg: shared types and constants of the full-circle atan2 block
// Widths, the arctangent table, the queue record and the CORDIC step.
// ---------------------------------------------------------------------------
package fca_pkg;

  localparam int COMP_W         = 16;
  localparam int ANGLE_W        = 16;
  localparam int ROTATION_STEPS = 16;

  localparam int TABLE_LEN   = 32;
  localparam int STEPS       = (ROTATION_STEPS > TABLE_LEN) ? TABLE_LEN : ROTATION_STEPS;
  localparam int GUARD_SHIFT = 40 - COMP_W;
  localparam int DP_W        = 44;
  localparam int Z_W         = 32;
  localparam int ROUND_SH    = Z_W - ANGLE_W;

  localparam logic [Z_W-1:0] TURN_ZERO     = 32'h0000_0000;
  localparam logic [Z_W-1:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [Z_W-1:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [Z_W-1:0] TURN_3QUARTER = 32'hC000_0000;

  localparam logic [Z_W:0] ROUND_HALF =
    (ROUND_SH > 0) ? ((Z_W+1)'(1) << (ROUND_SH - 1)) : '0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  localparam logic [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                   exact;
    logic signed [DP_W-1:0] x;
    logic signed [DP_W-1:0] y;
    logic [Z_W-1:0]         z;
  } vec_rec_t;

  // One micro-rotation; an exact axis answer passes through unchanged.
  function automatic vec_rec_t cordic_step(input vec_rec_t r, input int i);
    logic signed [DP_W-1:0] xv;
    logic signed [DP_W-1:0] yv;
    logic signed [DP_W-1:0] xs;
    logic signed [DP_W-1:0] ys;
    vec_rec_t               o;
    xv = r.x;
    yv = r.y;
    xs = xv >>> i;
    ys = yv >>> i;
    o  = r;
    if (!r.exact) begin
      if (!yv[DP_W-1]) begin
        o.x = xv + ys;
        o.y = yv - xs;
        o.z = r.z + ATAN_TAB[i];
      end else begin
        o.x = xv - ys;
        o.y = yv + xs;
        o.z = r.z - ATAN_TAB[i];
      end
    end
    return o;
  endfunction

  function automatic logic [ANGLE_W-1:0] round_angle(input logic [Z_W-1:0] z);
    logic [Z_W:0] sum;
    sum = {1'b0, z} + ROUND_HALF;
    return ANGLE_W'(sum >> ROUND_SH);
  endfunction

endpackage

// ----- rtl/fca_if.sv -----
// ---------------------------------------------------------------------------
// fca_if: request channels of the full-circle atan2 block
// Valid/ready channels for the vector input and the angle result.
// ---------------------------------------------------------------------------
interface fca_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [fca_pkg::COMP_W-1:0] opposite;
  logic signed [fca_pkg::COMP_W-1:0] adjacent;

  modport source (output valid, output opposite, output adjacent, input ready);
  modport sink (input valid, input opposite, input adjacent, output ready);
endinterface

interface fca_out_if;
  logic                        valid;
  logic                        ready;
  logic [fca_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

// ----- rtl/fca_front.sv -----
// ---------------------------------------------------------------------------
// fca_front: request intake and classification
// Answers the axis cases exactly and pre-rotates the other vectors into
// the right half plane before they are queued.
// ---------------------------------------------------------------------------
module fca_front (
  fca_in_if.sink              in_chan,
  input  logic                q_full,
  output logic                push,
  output fca_pkg::vec_rec_t   push_rec
);
  import fca_pkg::*;

  logic signed [DP_W-1:0] xg;
  logic signed [DP_W-1:0] yg;
  logic                   y_zero;
  logic                   x_zero;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  assign xg     = {{(DP_W-40){in_chan.adjacent[COMP_W-1]}}, in_chan.adjacent,
                   {GUARD_SHIFT{1'b0}}};
  assign yg     = {{(DP_W-40){in_chan.opposite[COMP_W-1]}}, in_chan.opposite,
                   {GUARD_SHIFT{1'b0}}};
  assign y_zero = (in_chan.opposite == '0);
  assign x_zero = (in_chan.adjacent == '0);

  always_comb begin
    push_rec.exact = y_zero || x_zero;
    push_rec.x     = xg;
    push_rec.y     = yg;
    push_rec.z     = TURN_ZERO;
    if (y_zero) begin
      push_rec.z = (!xg[DP_W-1] && !x_zero) ? TURN_ZERO : TURN_HALF;
    end else if (x_zero) begin
      push_rec.z = yg[DP_W-1] ? TURN_3QUARTER : TURN_QUARTER;
    end else if (xg[DP_W-1]) begin
      push_rec.x = -xg;
      push_rec.y = -yg;
      push_rec.z = TURN_HALF;
    end
  end

endmodule

// ----- rtl/fca_queue.sv -----
// ---------------------------------------------------------------------------
// fca_queue: short request queue between intake and CORDIC pipeline
// Two-entry FIFO; a push and a pop may happen in the same cycle.
// ---------------------------------------------------------------------------
module fca_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  fca_pkg::vec_rec_t  push_rec,
  input  logic               pop,
  output logic               q_full,
  output logic               q_valid,
  output fca_pkg::vec_rec_t  head_rec
);
  import fca_pkg::*;

  vec_rec_t               entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr_r;
  logic [QUEUE_AW-1:0]    wr_ptr_nxt;
  logic [QUEUE_AW-1:0]    rd_ptr_r;
  logic [QUEUE_AW-1:0]    rd_ptr_nxt;
  logic [QUEUE_CW-1:0]    count_r;
  logic [QUEUE_CW-1:0]    count_nxt;
  logic                   do_pop;

  assign q_full   = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign head_rec = entry_r[rd_ptr_r];
  assign do_pop   = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QUEUE_CW'(push) - QUEUE_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ----- rtl/fca_cordic.sv -----
// ---------------------------------------------------------------------------
// fca_cordic: pipelined CORDIC vectoring back end
// One micro-rotation per stage, then a rounding stage that drives the
// result channel. The whole pipeline holds while a result waits.
// ---------------------------------------------------------------------------
module fca_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  fca_pkg::vec_rec_t  head_rec,
  output logic               pop,
  fca_out_if.source          out_chan
);
  import fca_pkg::*;

  vec_rec_t           stage_r [STEPS];
  logic [STEPS:0]     vld_r;
  logic [ANGLE_W-1:0] angle_r;
  logic               adv;

  assign adv            = !vld_r[STEPS] || out_chan.ready;
  assign pop            = adv;
  assign out_chan.valid = vld_r[STEPS];
  assign out_chan.angle = angle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STEPS-1:0], q_valid};
    end
  end

  genvar k;
  generate
    for (k = 0; k < STEPS; k++) begin : g_stage
      if (k == 0) begin : g_first
        always_ff @(posedge clk) begin
          if (adv) begin
            stage_r[k] <= cordic_step(head_rec, k);
          end
        end
      end else begin : g_next
        always_ff @(posedge clk) begin
          if (adv) begin
            stage_r[k] <= cordic_step(stage_r[k-1], k);
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (adv) begin
      angle_r <= round_angle(stage_r[STEPS-1].z);
    end
  end

endmodule

// ----- rtl/full_circle_atan2_top.sv -----
// ---------------------------------------------------------------------------
// full_circle_atan2_top: atan2 over the full circle as a binary angle
// A request passes through the queue, one pipeline stage per micro-rotation
// and a rounding stage. Throughput is one request per cycle while the result
// channel is ready, set by the one-stage-per-rotation CORDIC pipeline; a
// stalled result holds the pipeline and fills the queue.
// Synchronous reset clears the queue and all pipeline valid flags.
// ---------------------------------------------------------------------------
module full_circle_atan2_top (
  input  logic       clk,
  input  logic       rst_n,
  fca_in_if.sink     in_chan,
  fca_out_if.source  out_chan
);
  import fca_pkg::*;

  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_valid;
  vec_rec_t push_rec;
  vec_rec_t head_rec;

  fca_front u_front (
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  fca_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .head_rec (head_rec)
  );

  fca_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head_rec (head_rec),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
